// ----- design/frustum_sphere_cull_macros.svh -----
// Assertion macros for the frustum sphere cull block.
`ifndef FRUSTUM_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_MACROS_SVH
`ifndef SYNTH
`define FSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frustum_sphere_cull check failed");
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frustum_sphere_cull check failed");
`else
`define FSC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/fsc_pkg.sv -----
// Shared types, constants and plane tables for the frustum sphere cull block.
package fsc_pkg;

   localparam int Q_W        = 32;
   localparam int RAD_W      = 31;
   localparam int NUM_PAIRS  = 8;
   localparam int NUM_PLANES = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;
   localparam int PS_DEPTH   = 24;
   localparam int PS_AW      = 5;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 48;
   localparam int ACC_W      = 50;

   localparam logic [CSR_DATA_W-1:0] MATRIX_RESET [NUM_PAIRS] = '{
      64'd65536, 64'd0, 64'd281474976710656, 64'd0,
      64'd0, 64'd65536, 64'd0, 64'd281474976710656
   };

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_RAW  = 7'b0000010,
      ST_SQ   = 7'b0000100,
      ST_SQRT = 7'b0001000,
      ST_DIV  = 7'b0010000,
      ST_DIST = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             raw_ld;
      logic             sq_mul;
      logic             sqrt_init;
      logic             sqrt_step;
      logic             div_init;
      logic             div_step;
      logic             ram_we;
      logic             rd_en;
      logic [2:0]       plane;
      logic [1:0]       comp;
      logic [PS_AW-1:0] rd_addr;
   } cmd_type;

   typedef struct packed {
      logic in_frustum;
   } sts_type;

   // Row other than row 3 that feeds each plane.
   function automatic logic [1:0] plane_orow(input logic [2:0] p);
      return p[2:1];
   endfunction

   // Planes that subtract the other row.
   function automatic logic plane_neg(input logic [2:0] p);
      return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
   endfunction

   // Planes that include row 3 (all but near).
   function automatic logic plane_w3(input logic [2:0] p);
      return p != 3'd4;
   endfunction

   function automatic logic signed [Q_W-1:0] sat34(input logic signed [Q_W+1:0] v);
      if (v > 34'sh0_7FFF_FFFF) return Q_MAX;
      else if (v < -34'sh0_8000_0000) return Q_MIN;
      else return v[Q_W-1:0];
   endfunction

endpackage

// ----- design/fsc_if.sv -----
// Request and response channel interfaces for the frustum sphere cull block.
interface fsc_req_if import fsc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] center_x;
   logic signed [Q_W-1:0] center_y;
   logic signed [Q_W-1:0] center_z;
   logic [RAD_W-1:0]      sphere_radius;
   modport source (output valid, center_x, center_y, center_z, sphere_radius,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, sphere_radius,
                 output ready);
endinterface

interface fsc_rsp_if ();
   logic valid;
   logic ready;
   logic inside_res;
   modport source (output valid, inside_res, input ready);
   modport sink (input valid, inside_res, output ready);
endinterface

// ----- design/fsc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- design/fsc_datapath.sv -----
// Datapath: matrix registers, plane build arithmetic, plane store and distance test.
module fsc_datapath import fsc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic signed [Q_W-1:0]   center_x,
   input  logic signed [Q_W-1:0]   center_y,
   input  logic signed [Q_W-1:0]   center_z,
   input  logic [RAD_W-1:0]        sphere_radius,
   input  cmd_type                 cmd,
   output sts_type                 sts
);
   logic [CSR_DATA_W-1:0]   matrix_ff [NUM_PAIRS];
   logic signed [Q_W-1:0]   ent [16];
   logic signed [Q_W-1:0]   raw_in [4];
   logic signed [Q_W-1:0]   raw_ff [4];
   logic signed [Q_W-1:0]   cx_ff, cy_ff, cz_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic signed [Q_W-1:0]   mul_a, mul_b;
   logic signed [63:0]      prod_ff;
   logic                    sqv_ff, dpv_ff;
   logic [63:0]             lsq_ff;
   logic [63:0]             sv_ff, sres_ff, sbit_ff, srb;
   logic [47:0]             dvd_ff, quo_ff;
   logic [31:0]             rem_ff;
   logic [32:0]             rem_sh;
   logic [31:0]             len;
   logic [31:0]             mag;
   logic signed [Q_W-1:0]   qval;
   logic [Q_W-1:0]          rdata;
   logic                    tag_vld_ff;
   logic [1:0]              tag_k_ff;
   logic signed [Q_W-1:0]   cmul;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    chk_ff;
   logic signed [Q_W-1:0]   dist_sat;
   logic signed [Q_W:0]     negr;
   logic                    inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PAIRS; i++) matrix_ff[i] <= MATRIX_RESET[i];
      end else if (csr_we && (csr_index < CSR_IDX_W'(NUM_PAIRS))) begin
         matrix_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         ent[i] = i[0] ? matrix_ff[i >> 1][63:32] : matrix_ff[i >> 1][31:0];
      end
   end

   // Raw plane components for the commanded plane.
   always_comb begin
      logic signed [Q_W+1:0] o;
      logic signed [Q_W+1:0] s;
      for (int k = 0; k < 4; k++) begin
         o = {{2{ent[{plane_orow(cmd.plane), 2'(k)}][Q_W-1]}},
              ent[{plane_orow(cmd.plane), 2'(k)}]};
         if (plane_neg(cmd.plane)) o = -o;
         s = o;
         if (plane_w3(cmd.plane)) begin
            s = o + {{2{ent[{2'd3, 2'(k)}][Q_W-1]}}, ent[{2'd3, 2'(k)}]};
         end
         raw_in[k] = sat34(s);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.raw_ld) begin
         for (int k = 0; k < 4; k++) raw_ff[k] <= raw_in[k];
      end
      if (cmd.capture) begin
         cx_ff  <= center_x;
         cy_ff  <= center_y;
         cz_ff  <= center_z;
         rad_ff <= sphere_radius;
      end
   end

   // Shared multiplier: squares during plane build, distance terms during test.
   always_comb begin
      unique case (tag_k_ff)
         2'd0:    cmul = cx_ff;
         2'd1:    cmul = cy_ff;
         2'd2:    cmul = cz_ff;
         default: cmul = '0;
      endcase
      if (cmd.sq_mul) begin
         mul_a = raw_ff[cmd.comp];
         mul_b = raw_ff[cmd.comp];
      end else begin
         mul_a = $signed(rdata);
         mul_b = cmul;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_mul || (tag_vld_ff && tag_k_ff != 2'd3)) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff     <= 1'b0;
         dpv_ff     <= 1'b0;
         tag_vld_ff <= 1'b0;
         chk_ff     <= 1'b0;
      end else begin
         sqv_ff     <= cmd.sq_mul;
         dpv_ff     <= tag_vld_ff && (tag_k_ff != 2'd3);
         tag_vld_ff <= cmd.rd_en;
         chk_ff     <= tag_vld_ff && (tag_k_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      tag_k_ff <= cmd.rd_addr[1:0];
      if (cmd.raw_ld) lsq_ff <= '0;
      else if (sqv_ff) lsq_ff <= lsq_ff + prod_ff;
   end

   // Integer square root, one result bit per step.
   assign srb = sres_ff + sbit_ff;

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sv_ff   <= lsq_ff;
         sres_ff <= '0;
         sbit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (sv_ff >= srb) begin
            sv_ff   <= sv_ff - srb;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
   end

   assign len = sres_ff[31:0];

   // Restoring divider for (|raw| << 16) / len.
   assign mag    = raw_ff[cmd.comp][Q_W-1] ? 32'(-raw_ff[cmd.comp]) : 32'(raw_ff[cmd.comp]);
   assign rem_sh = {rem_ff, dvd_ff[47]};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff <= {mag, 16'd0};
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[46:0], 1'b0};
         if (rem_sh >= {1'b0, len}) begin
            rem_ff <= 32'(rem_sh - {1'b0, len});
            quo_ff <= {quo_ff[46:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[31:0];
            quo_ff <= {quo_ff[46:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (len == '0) begin
         qval = '0;
      end else if (raw_ff[cmd.comp][Q_W-1]) begin
         if (quo_ff > 48'h0000_8000_0000) qval = Q_MIN;
         else qval = -$signed(quo_ff[Q_W-1:0]);
      end else begin
         if (quo_ff > 48'h0000_7FFF_FFFF) qval = Q_MAX;
         else qval = $signed(quo_ff[Q_W-1:0]);
      end
   end

   fsc_ram #(
      .WIDTH(Q_W),
      .DEPTH(PS_DEPTH)
   ) u_plane_store (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr ({cmd.plane, cmd.comp}),
      .wdata (qval),
      .re    (cmd.rd_en),
      .raddr (cmd.rd_addr),
      .rdata (rdata)
   );

   // Distance accumulate: clear on component a, add d on component d.
   always_comb begin
      acc_in = (tag_vld_ff && tag_k_ff == 2'd0) ? '0 : acc_ff;
      if (dpv_ff) acc_in = acc_in + ACC_W'($signed(prod_ff[63:16]));
      if (tag_vld_ff && tag_k_ff == 2'd3) begin
         acc_in = acc_in + ACC_W'($signed(rdata));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   always_comb begin
      if (acc_ff > ACC_W'(Q_MAX)) dist_sat = Q_MAX;
      else if (acc_ff < ACC_W'(Q_MIN)) dist_sat = Q_MIN;
      else dist_sat = acc_ff[Q_W-1:0];
      negr = -$signed({2'b00, rad_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b1;
      end else if (cmd.capture) begin
         inside_ff <= 1'b1;
      end else if (chk_ff && ((Q_W+1)'(dist_sat) < negr)) begin
         inside_ff <= 1'b0;
      end
   end

   assign sts.in_frustum = inside_ff;
endmodule

// ----- design/fsc_ctrl.sv -----
// Controller: sequences plane rebuild, distance test and the result register.
module fsc_ctrl import fsc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_inside,
   output cmd_type              cmd,
   input  sts_type              sts
);
   state_type  state_ff, state_in;
   logic [2:0] p_ff, p_in;
   logic [1:0] k_ff, k_in;
   logic [5:0] it_ff, it_in;
   logic       cur_ff, cur_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       rsp_ins_ff, rsp_ins_in;
   logic       out_load;

   always_comb begin
      state_in   = state_ff;
      p_in       = p_ff;
      k_in       = k_ff;
      it_in      = it_ff;
      cur_in     = cur_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_ins_in = rsp_ins_ff;
      req_ready  = 1'b0;
      out_load   = 1'b0;
      cmd        = '0;
      cmd.plane  = p_ff;
      cmd.comp   = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               it_in       = '0;
               p_in        = '0;
               k_in        = '0;
               state_in    = cur_ff ? ST_DIST : ST_RAW;
            end
         end
         ST_RAW: begin
            cmd.raw_ld = 1'b1;
            it_in      = '0;
            state_in   = ST_SQ;
         end
         ST_SQ: begin
            if (it_ff < 6'd3) begin
               cmd.sq_mul = 1'b1;
               cmd.comp   = it_ff[1:0];
            end
            // wait for the last square to land in the length sum
            if (it_ff == 6'd4) begin
               cmd.sqrt_init = 1'b1;
               it_in         = '0;
               state_in      = ST_SQRT;
            end else begin
               it_in = it_ff + 6'd1;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (it_ff == 6'(SQRT_STEPS - 1)) begin
               it_in    = '0;
               k_in     = '0;
               state_in = ST_DIV;
            end else begin
               it_in = it_ff + 6'd1;
            end
         end
         ST_DIV: begin
            if (it_ff == 6'd0) begin
               cmd.div_init = 1'b1;
               it_in        = it_ff + 6'd1;
            end else if (it_ff <= 6'(DIV_STEPS)) begin
               cmd.div_step = 1'b1;
               it_in        = it_ff + 6'd1;
            end else begin
               cmd.ram_we = 1'b1;
               it_in      = '0;
               if (k_ff == 2'd3) begin
                  k_in = '0;
                  if (p_ff == 3'(NUM_PLANES - 1)) begin
                     cur_in   = 1'b1;
                     state_in = ST_DIST;
                  end else begin
                     p_in     = p_ff + 3'd1;
                     state_in = ST_RAW;
                  end
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         ST_DIST: begin
            if (it_ff < 6'(PS_DEPTH)) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = it_ff[PS_AW-1:0];
            end
            // last plane check lands through the read tag and check registers after its last read
            if (it_ff == 6'(PS_DEPTH + 1)) begin
               state_in = ST_OUT;
            end else begin
               it_in = it_ff + 6'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_vld_ff || rsp_ready) begin
               out_load   = 1'b1;
               rsp_vld_in = 1'b1;
               rsp_ins_in = sts.in_frustum;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we && (csr_index < CSR_IDX_W'(NUM_PAIRS))) begin
         cur_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         p_ff       <= '0;
         k_ff       <= '0;
         it_ff      <= '0;
         cur_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         p_ff       <= p_in;
         k_ff       <= k_in;
         it_ff      <= it_in;
         cur_ff     <= cur_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_ins_ff <= rsp_ins_in;
   end

   assign rsp_valid  = rsp_vld_ff;
   assign rsp_inside = rsp_ins_ff;
endmodule

// ----- design/frustum_sphere_cull.sv -----
// Top level of the frustum sphere cull block.
//
// Load a 4x4 projection-view matrix (sixteen signed Q16.16 entries, two per
// 64-bit register) through the csr_ write port while the block is idle. Send
// spheres on req_chan (center x/y/z, radius); each transfer yields one
// inside_res bit on rsp_chan: 0 when the sphere lies fully behind one of the
// six clip planes, 1 otherwise.
// After reset or any matrix write, the first sphere triggers a plane rebuild:
// per plane a raw load, the square phase, 32 square-root steps and four
// restoring divisions, one per component. The divider and square-root unit,
// one bit per cycle, set the rebuild time.
// With planes current, a sphere is tested by 24 plane-store reads through the
// single RAM read port, one per cycle, its a, b and c terms feeding one shared
// 32x32 multiplier; then the pipeline drains and the result is loaded into the
// output register.
// One sphere is in flight at a time. A finished result waits in the output
// register while the next sphere is accepted; if the receiver stalls, the
// following result holds until that register frees.
// Reset is synchronous, restores the identity matrix and marks the planes
// for rebuild.
module frustum_sphere_cull import fsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fsc_req_if.sink               req_chan,
   fsc_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
`include "frustum_sphere_cull_macros.svh"

   cmd_type cmd;
   sts_type sts;

   fsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_inside (rsp_chan.inside_res),
      .cmd        (cmd),
      .sts        (sts)
   );

   fsc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .center_x      (req_chan.center_x),
      .center_y      (req_chan.center_y),
      .center_z      (req_chan.center_z),
      .sphere_radius (req_chan.sphere_radius),
      .cmd           (cmd),
      .sts           (sts)
   );

   `FSC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `FSC_ASSERT_IMPL(a_no_rw_overlap, clock, reset, cmd.ram_we, !cmd.rd_en)
   `FSC_ASSERT_IMPL(a_one_op, clock, reset, 1'b1, $onehot0({cmd.raw_ld, cmd.sq_mul, cmd.sqrt_step, cmd.div_step, cmd.ram_we, cmd.rd_en}))
endmodule

// ----- dv/fsc_checker.sv -----
// Scoreboard for the frustum sphere cull block: tracks the matrix, predicts cull verdicts, compares.
`timescale 1ns / 100ps

module fsc_checker import fsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   fsc_req_if                    req,
   fsc_rsp_if                    rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending,
   output int                    checked,
   output int                    culled
);

   logic [CSR_DATA_W-1:0] matrix_regs [NUM_PAIRS];
   logic signed [Q_W-1:0] clip_planes [PS_DEPTH];
   bit                    planes_stale;
   bit                    inside_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      culled     = 0;
   end

   function automatic longint clamp_q(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint matrix_entry(input int i);
      logic [Q_W-1:0] w;
      w = (i % 2) ? matrix_regs[i/2][63:32] : matrix_regs[i/2][31:0];
      return longint'($signed(w));
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v   = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   // Derive the six normalized planes from the current matrix.
   function automatic void rebuild_planes();
      longint          raw [4];
      longint unsigned len_sq, len, mag;
      longint          m, v;
      int              orow;
      bit              neg, with_row3;
      for (int p = 0; p < NUM_PLANES; p++) begin
         orow      = p / 2;
         neg       = (p == 1) || (p == 2) || (p == 5);
         with_row3 = (p != 4);
         len_sq    = 0;
         for (int k = 0; k < 4; k++) begin
            v = neg ? -matrix_entry(orow * 4 + k) : matrix_entry(orow * 4 + k);
            if (with_row3) v = v + matrix_entry(12 + k);
            raw[k] = clamp_q(v);
         end
         for (int k = 0; k < 3; k++) len_sq = len_sq + longint'(raw[k] * raw[k]);
         len = floor_sqrt(len_sq);
         for (int k = 0; k < 4; k++) begin
            if (len == 0) begin
               clip_planes[p*4+k] = '0;
            end else begin
               mag = (raw[k] < 0) ? -raw[k] : raw[k];
               m   = longint'((mag << 16) / len);
               clip_planes[p*4+k] = Q_W'(clamp_q((raw[k] < 0) ? -m : m));
            end
         end
      end
      planes_stale = 0;
   endfunction

   function automatic bit sphere_inside(input logic [Q_W-1:0] cx, cy, cz,
                                        input logic [RAD_W-1:0] rad);
      longint ctr [3];
      longint plane_dist, neg_rad;
      ctr[0]  = longint'($signed(cx));
      ctr[1]  = longint'($signed(cy));
      ctr[2]  = longint'($signed(cz));
      neg_rad = -longint'(rad);
      if (planes_stale) rebuild_planes();
      for (int p = 0; p < NUM_PLANES; p++) begin
         plane_dist = longint'(clip_planes[p*4+3]);
         for (int k = 0; k < 3; k++)
            plane_dist = plane_dist + ((longint'(clip_planes[p*4+k]) * ctr[k]) >>> 16);
         if (clamp_q(plane_dist) < neg_rad) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         foreach (matrix_regs[i]) matrix_regs[i] = MATRIX_RESET[i];
         planes_stale = 1;
         inside_q.delete();
      end else begin
         if (csr_we && csr_index < NUM_PAIRS) begin
            matrix_regs[csr_index] = csr_wdata;
            planes_stale = 1;
         end
         if (rsp.valid && rsp.ready) begin
            if (inside_q.size() == 0) begin
               report_mismatch($sformatf("result %0b with nothing outstanding",
                                         rsp.inside_res));
            end else begin
               want = inside_q.pop_front();
               checked++;
               if (!want) culled++;
               if (rsp.inside_res !== want)
                  report_mismatch($sformatf("inside_res got %b want %b",
                                            rsp.inside_res, want));
            end
         end
         if (req.valid && req.ready)
            inside_q.push_back(sphere_inside(req.center_x, req.center_y,
                                             req.center_z, req.sphere_radius));
      end
      pending = inside_q.size();
   end

endmodule

// ----- dv/tb.sv -----
// Top-level testbench for the frustum sphere cull block: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb;
   import fsc_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_PER_SET = 115;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count, pending, checked, culled;
   int                    idle_count;
   int                    stall_left;
   bit                    no_stall;
   bit                    no_gap;
   int                    sent;

   fsc_req_if req_chan ();
   fsc_rsp_if rsp_chan ();

   frustum_sphere_cull u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fsc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .culled     (culled)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.center_x      = '0;
      req_chan.center_y      = '0;
      req_chan.center_z      = '0;
      req_chan.sphere_radius = '0;
      rsp_chan.ready         = 1'b0;
      idle_count             = 0;
      stall_left             = 0;
      no_stall               = 0;
      no_gap                 = 0;
      sent                   = 0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!no_stall) stall_left = gap_length();
      end
   end

   // Stop on a long stretch with no transfer at all.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_sphere(input logic [Q_W-1:0] cx, cy, cz,
                              input logic [RAD_W-1:0] rad);
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.center_x      <= cx;
      req_chan.center_y      <= cy;
      req_chan.center_z      <= cz;
      req_chan.sphere_radius <= rad;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic end_burst();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Leave the write enable high; the caller drops it after the last write.
   task automatic write_csr(input int idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= data;
      @(posedge clock);
   endtask

   function automatic logic [Q_W-1:0] pick_entry(input int kind);
      case (kind)
         0: return $urandom_range(0, 1) ? Q_W'($urandom_range(0, 131072))
                                        : -Q_W'($urandom_range(0, 131072));
         1: return 32'h0000_0000;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: begin
            case ($urandom_range(0, 5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'h0000_0001;
               4: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic load_matrix(input int kind);
      for (int i = 0; i < NUM_PAIRS; i++)
         write_csr(i, {pick_entry(kind), pick_entry(kind)});
   endtask

   function automatic logic [Q_W-1:0] pick_coord(input int mode);
      int mag;
      if (mode < 6) mag = $urandom_range(0, 1 << 19);
      else if (mode < 8) mag = $urandom_range(0, 1 << 24);
      else return $urandom;
      return $urandom_range(0, 1) ? Q_W'(mag) : -Q_W'(mag);
   endfunction

   task automatic random_spheres(input int count);
      int mode;
      logic [RAD_W-1:0] rad;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         if ($urandom_range(0, 9) < 7) rad = RAD_W'($urandom_range(0, 1 << 18));
         else rad = RAD_W'($urandom);
         send_sphere(pick_coord(mode), pick_coord(mode), pick_coord(mode), rad);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity planes from reset: field extremes and boundary spheres.
      send_sphere(32'h0, 32'h0, 32'h0, '0);
      send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
      send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
      send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, {RAD_W{1'b1}});
      send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, {RAD_W{1'b1}});
      send_sphere(32'h0002_0000, 32'h0, 32'h0, 31'h0001_0000);
      send_sphere(32'h0002_0001, 32'h0, 32'h0, 31'h0001_0000);
      send_sphere(32'hFFFE_0000, 32'h0, 32'h0, 31'h0001_0000);
      send_sphere(32'h0, 32'h0002_0000, 32'h0, 31'h0000_FFFF);
      send_sphere(32'h0, 32'hFFFD_0000, 32'h0, 31'h0001_0000);
      send_sphere(32'h0, 32'h0, 32'hFFFF_0000, '0);
      send_sphere(32'h0, 32'h0, 32'hFFFE_FFFF, '0);
      send_sphere(32'h0, 32'h0, 32'h0003_0000, 31'h0001_FFFF);
      send_sphere(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA);
      send_sphere(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 31'h5555_5555);
      send_sphere(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 31'h1);
      random_spheres(RANDOM_PER_SET);
      end_burst();

      // Matrix sets: random moderate, zero (degenerate planes), saturated, mixed, fully random, identity.
      for (int set = 0; set < 8; set++) begin
         no_gap   = (set == 3);
         no_stall = (set == 3) || (set == 6);
         case (set)
            0: load_matrix(0);
            1: load_matrix(1);
            2: load_matrix(2);
            3: load_matrix(3);
            4: load_matrix(4);
            5: load_matrix(5);
            6: begin
               load_matrix(0);
               // Writes past the register file must be dropped.
               for (int i = NUM_PAIRS; i < (1 << CSR_IDX_W); i++)
                  write_csr(i, {$urandom, $urandom});
            end
            default: for (int i = 0; i < NUM_PAIRS; i++) write_csr(i, MATRIX_RESET[i]);
         endcase
         csr_we <= 1'b0;
         random_spheres(RANDOM_PER_SET);
         end_burst();
      end

      $display("Sent %0d spheres over 9 matrix settings; checked %0d results, %0d culled.",
               sent, checked, culled);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
